// ===== src/tca_pkg.sv =====
// Package of types, constants and helpers shared by the thread count autotuner.
package tca_pkg;

    // Sizes of the block.
    localparam int MAX_THREADS = 64;
    localparam int TIME_BITS   = 32;
    localparam int CNT_W       = 7;
    localparam int TOL_W       = 17;
    localparam int CFG_W       = 17;
    localparam int RAM_DEPTH   = MAX_THREADS + 1;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);

    // Signed width of the slope divider and its iteration counter.
    localparam int DIV_BITS    = 52;
    localparam int DIV_CNT_W   = $clog2(DIV_BITS);

    // Prediction arithmetic and the serial tolerance multiply.
    localparam int PRED_W      = 64;
    localparam int PROD_W      = PRED_W + TOL_W - 1;

    localparam logic [31:0]      GOLD_Q32  = 32'd1640531526;
    localparam logic [TOL_W-1:0] TOL_ONE   = 17'd65536;

    // Search phase, numbered as reported on the result channel.
    typedef enum logic [3:0] {
        PH_WARM1  = 4'd0,
        PH_WARM2  = 4'd1,
        PH_FULL   = 4'd2,
        PH_HALF   = 4'd3,
        PH_TQ     = 4'd4,
        PH_GOLDEN = 4'd5,
        PH_TDONE  = 4'd6,
        PH_CWARM  = 4'd7,
        PH_CMEAS  = 4'd8,
        PH_SWARM  = 4'd9,
        PH_SMEAS  = 4'd10,
        PH_DONE   = 4'd11
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LIMIT = 2'd0,
        CFG_TOL   = 2'd1,
        CFG_STOP  = 2'd2,
        CFG_PLACE = 2'd3
    } cfg_index_t;

    // Sequencer states of the top level.
    typedef enum logic [4:0] {
        S_IDLE,
        S_STEP,
        S_SAT_A,
        S_SAT_B,
        S_SAT_C,
        S_SAT_D,
        S_NW_A,
        S_NW_B,
        S_NW_C,
        S_NW_D,
        S_NW_F,
        S_NW_G,
        S_NW_S,
        S_NW_M,
        S_NW_INIT,
        S_NW_SCAN1,
        S_NW_MULI,
        S_NW_MUL,
        S_NW_BND,
        S_NW_SCAN2,
        S_BM_INIT,
        S_BM_RD,
        S_BM_CMP,
        S_FIN,
        S_GOLD,
        S_GOLD_RL,
        S_GOLD_RR,
        S_GOLD_CMP,
        S_GOLD_END,
        S_OUT
    } seq_state_t;

    // Golden-section offset: floor(span * 0.381966...).
    function automatic logic [CNT_W-1:0] gold_offset(input logic [CNT_W-1:0] span);
        logic [CNT_W+31:0] prod;
        prod = {{CNT_W{1'b0}}, GOLD_Q32} * {{32{1'b0}}, span};
        return prod[CNT_W+31:32];
    endfunction

    // Sample store address of a thread count; counts beyond the store map to zero.
    function automatic logic [ADDR_W-1:0] sample_index(input logic [CNT_W-1:0] t);
        if (t > CNT_W'(MAX_THREADS)) begin
            return '0;
        end
        return ADDR_W'(t);
    endfunction

endpackage

// ===== src/tca_if.sv =====
// Valid/ready channel interfaces for measured times and tuning results.
interface tca_in_if;
    import tca_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] elapsed_time;

    modport source (output valid, output elapsed_time, input ready);
    modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface tca_out_if;
    import tca_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] next_threads;
    logic             next_placement;
    logic [3:0]       phase_code;
    logic             tuning_done;

    modport source (output valid, output next_threads, output next_placement,
                    output phase_code, output tuning_done, input ready);
    modport sink   (input valid, input next_threads, input next_placement,
                    input phase_code, input tuning_done, output ready);
endinterface

// ===== src/tca_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tca_divider.sv =====
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
module tca_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tca_pkg::DIV_BITS-1:0] dividend,
    input  logic        [tca_pkg::CNT_W-1:0]    divisor,
    output logic                                done,
    output logic signed [tca_pkg::DIV_BITS-1:0] quotient
);
    import tca_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DIV_BITS-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;

    logic [CNT_W:0]       trial;
    logic                 fits;

    // One trial subtraction of the divisor from the partial remainder.
    always_comb
    begin
        trial = {rem_reg, num_reg[DIV_BITS-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    // Sequencing of the iterations.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = DIV_CNT_W'(DIV_BITS - 1);
            num_next   = dividend[DIV_BITS-1] ? $unsigned(-dividend) : $unsigned(dividend);
            rem_next   = '0;
            den_next   = divisor;
            neg_next   = dividend[DIV_BITS-1];
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_BITS-2:0], fits};
            rem_next = fits ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

// ===== src/thread_count_autotuner_top.sv =====
// Top level of the thread count autotuner: sequencer, search state and sample store.
//
//  Channel   Dir  Fields                                              Handshake
//  measure   in   elapsed_time[31:0]                                  valid/ready
//  outcome   out  next_threads[6:0] next_placement phase_code[3:0]    valid/ready
//                 tuning_done
//  cfg       in   cfg_index[1:0] cfg_data[16:0]                       cfg_write
//
// One word is taken at a time; ready is low from acceptance until its result is taken.
// Warmup, placement, full and half steps go through S_STEP straight to S_OUT.
// The Newton path spends its time mainly in three slope divisions and, when it falls
// back, in the best-sample walk, which reads and compares each thread count in turn.
// Reset clears the valid bits of the sample store at once; no clearing pass follows.
// A stalled result holds the block in its output state with all fields steady.
module thread_count_autotuner_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  tca_pkg::cfg_index_t       cfg_index,
    input  logic [tca_pkg::CFG_W-1:0] cfg_data,
    tca_in_if.sink                    measure,
    tca_out_if.source                 outcome
);
    import tca_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [TOL_W-1:0] tol_reg, tol_next;
    logic [CNT_W-1:0] stop_reg, stop_next;
    logic             place_reg, place_next;

    // Search state.
    seq_state_t           seq_reg, seq_next;
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     run_thr_reg, run_thr_next;
    logic [CNT_W-1:0]     chosen_thr_reg, chosen_thr_next;
    logic                 run_pl_reg, run_pl_next;
    logic                 chosen_pl_reg, chosen_pl_next;
    logic [CNT_W-1:0]     low_reg, low_next;
    logic [CNT_W-1:0]     high_reg, high_next;
    logic [TIME_BITS-1:0] ctime_reg, ctime_next;
    logic [RAM_DEPTH-1:0] valid_reg, valid_next;

    // Working registers.
    logic [TIME_BITS-1:0]       meas_reg, meas_next;
    logic [TIME_BITS-1:0]       y0_reg, y0_next;
    logic [TIME_BITS-1:0]       y1_reg, y1_next;
    logic [TIME_BITS-1:0]       y2_reg, y2_next;
    logic [TIME_BITS-1:0]       den_reg, den_next;
    logic [TIME_BITS-1:0]       diff_reg, diff_next;
    logic signed [DIV_BITS-1:0] f_reg, f_next;
    logic signed [DIV_BITS-1:0] s_reg, s_next;
    logic signed [PRED_W-1:0]   m_reg, m_next;
    logic signed [PRED_W-1:0]   d0_reg, d0_next;
    logic signed [PRED_W-1:0]   d_reg, d_next;
    logic signed [PRED_W-1:0]   p_reg, p_next;
    logic signed [PRED_W-1:0]   best_reg, best_next;
    logic signed [PRED_W-1:0]   bound_reg, bound_next;
    logic                       have_reg, have_next;
    logic [CNT_W-1:0]           t_reg, t_next;
    logic                       found_reg, found_next;
    logic [TIME_BITS-1:0]       bv_reg, bv_next;
    logic [CNT_W-1:0]           bt_reg, bt_next;
    logic [CNT_W-1:0]           fin_reg, fin_next;
    logic [PROD_W-1:0]          mcand_reg, mcand_next;
    logic [TOL_W-1:0]           mplier_reg, mplier_next;
    logic [PROD_W-1:0]          acc_reg, acc_next;
    logic [$clog2(TOL_W)-1:0]   mcount_reg, mcount_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic [CNT_W-1:0]           right_reg, right_next;
    logic [TIME_BITS-1:0]       lt_reg, lt_next;

    // Effective limits.
    logic [CNT_W-1:0] lim, half, tq, stop_eff;
    logic [TOL_W-1:0] tol_eff;
    logic [CNT_W+1:0] lim3;
    logic [CNT_W:0]   stop_def;

    // Sample store port.
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [TIME_BITS-1:0] ram_rdata;

    // Divider port.
    logic                       div_start;
    logic signed [DIV_BITS-1:0] div_dividend;
    logic [CNT_W-1:0]           div_divisor;
    logic                       div_done;
    logic signed [DIV_BITS-1:0] div_quot;

    // Golden step helpers.
    logic [CNT_W-1:0] g_span, g_off, g_left, g_right, g_mid;
    logic             g_cont;

    // Arithmetic helpers.
    logic                           recordable;
    logic signed [TIME_BITS:0]      dy01, dy12;
    logic [TIME_BITS-1:0]           red_val;
    logic [TIME_BITS+TOL_W-1:0]     sat_prod;
    logic [TIME_BITS+TOL_W-1:0]     sat_lhs;
    logic signed [CNT_W+1:0]        w_off;
    logic signed [DIV_BITS+CNT_W+1:0] m_prod;
    logic signed [PRED_W-1:0]       s2;
    logic signed [PRED_W-1:0]       y0q;
    logic                           p_pos;
    logic                           bm_take;
    logic [PRED_W:0]                bound_sum;
    logic [CNT_W-1:0]               fin_clamped;

    // Effective register values.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (limit_reg > CNT_W'(MAX_THREADS))
        begin
            lim = CNT_W'(MAX_THREADS);
        end
        else
        begin
            lim = limit_reg;
        end
        half     = (lim >> 1) == '0 ? CNT_W'(1) : (lim >> 1);
        lim3     = (CNT_W+2)'(lim) * (CNT_W+2)'(3);
        tq       = lim3[CNT_W+1:2] == '0 ? CNT_W'(1) : lim3[CNT_W+1:2];
        stop_def = ((CNT_W+1)'(lim) + (CNT_W+1)'(7)) >> 3;
        stop_eff = stop_reg != '0 ? stop_reg : stop_def[CNT_W-1:0];
        tol_eff  = tol_reg > TOL_ONE ? TOL_ONE : tol_reg;
    end

    // Candidate points of one golden-section step.
    always_comb
    begin
        g_span  = high_reg - low_reg;
        g_off   = gold_offset(g_span);
        g_left  = low_reg + g_off;
        g_right = high_reg - g_off;
        if (g_left <= low_reg)
        begin
            g_left = low_reg + 1'b1;
        end
        if (g_right >= high_reg)
        begin
            g_right = high_reg - 1'b1;
        end
        g_mid  = low_reg + 1'b1;
        g_cont = (high_reg > low_reg) && (g_span > stop_eff);
    end

    // Shared arithmetic of the saturation test, the interpolation, the best-sample walk and the final clamp.
    always_comb
    begin
        recordable = (phase_reg == PH_FULL || phase_reg == PH_HALF ||
                      phase_reg == PH_TQ || phase_reg == PH_GOLDEN) &&
                     run_thr_reg != '0 && run_thr_reg <= lim;
        dy01       = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
        dy12       = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
        red_val    = ram_rdata;
        sat_prod   = (TIME_BITS+TOL_W)'(tol_eff) * (TIME_BITS+TOL_W)'(den_reg);
        sat_lhs    = (TIME_BITS+TOL_W)'({diff_reg, 16'd0});
        w_off      = $signed({2'b00, half}) + (CNT_W+2)'(1) - $signed({2'b00, tq});
        m_prod     = s_reg * w_off;
        s2         = {{(PRED_W-DIV_BITS-1){s_reg[DIV_BITS-1]}}, s_reg, 1'b0};
        y0q        = $signed({{(PRED_W-TIME_BITS-16){1'b0}}, y0_reg, 16'd0});
        p_pos      = p_reg > $signed(PRED_W'(0));
        bm_take    = valid_reg[sample_index(t_reg)] && (!found_reg || ram_rdata < bv_reg);
        bound_sum  = (PRED_W+1)'($unsigned(best_reg)) + (PRED_W+1)'(acc_reg[PROD_W-1:16]);
        if (fin_reg == '0)
        begin
            fin_clamped = CNT_W'(1);
        end
        else if (fin_reg > lim)
        begin
            fin_clamped = lim;
        end
        else
        begin
            fin_clamped = fin_reg;
        end
    end

    // Configuration writes.
    always_comb
    begin
        limit_next = limit_reg;
        tol_next   = tol_reg;
        stop_next  = stop_reg;
        place_next = place_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LIMIT: limit_next = cfg_data[CNT_W-1:0];
                CFG_TOL:   tol_next   = cfg_data[TOL_W-1:0];
                CFG_STOP:  stop_next  = cfg_data[CNT_W-1:0];
                CFG_PLACE: place_next = cfg_data[0];
            endcase
        end
    end

    // Sequencer: next state, search updates and datapath control.
    always_comb
    begin
        seq_next        = seq_reg;
        phase_next      = phase_reg;
        run_thr_next    = run_thr_reg;
        chosen_thr_next = chosen_thr_reg;
        run_pl_next     = run_pl_reg;
        chosen_pl_next  = chosen_pl_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        ctime_next      = ctime_reg;
        valid_next      = valid_reg;
        meas_next       = meas_reg;
        y0_next         = y0_reg;
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        den_next        = den_reg;
        diff_next       = diff_reg;
        f_next          = f_reg;
        s_next          = s_reg;
        m_next          = m_reg;
        d0_next         = d0_reg;
        d_next          = d_reg;
        p_next          = p_reg;
        best_next       = best_reg;
        bound_next      = bound_reg;
        have_next       = have_reg;
        t_next          = t_reg;
        found_next      = found_reg;
        bv_next         = bv_reg;
        bt_next         = bt_reg;
        fin_next        = fin_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        acc_next        = acc_reg;
        mcount_next     = mcount_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        lt_next         = lt_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        measure.ready   = 1'b0;
        outcome.valid   = 1'b0;

        unique case (seq_reg)
            S_IDLE:
            begin
                measure.ready = 1'b1;
                if (measure.valid)
                begin
                    meas_next = measure.elapsed_time;
                    seq_next  = S_STEP;
                end
            end

            // Store the sample of a sampling step, then advance the phase or hand over to the search.
            S_STEP:
            begin
                if (recordable)
                begin
                    ram_we = 1'b1;
                    valid_next[sample_index(run_thr_reg)] = 1'b1;
                end
                seq_next = S_OUT;
                unique case (phase_reg)
                    PH_WARM1:
                    begin
                        run_thr_next = lim;
                        phase_next   = PH_WARM2;
                    end
                    PH_WARM2:
                    begin
                        run_thr_next = lim;
                        phase_next   = PH_FULL;
                    end
                    PH_FULL:
                    begin
                        run_thr_next = half;
                        phase_next   = PH_HALF;
                    end
                    PH_HALF:
                    begin
                        run_thr_next = tq;
                        phase_next   = PH_TQ;
                    end
                    PH_TQ:     seq_next = S_SAT_A;
                    PH_GOLDEN: seq_next = S_GOLD;
                    PH_TDONE:
                    begin
                        fin_next = chosen_thr_reg;
                        seq_next = S_FIN;
                    end
                    PH_CWARM:  phase_next = PH_CMEAS;
                    PH_CMEAS:
                    begin
                        ctime_next  = meas_reg;
                        run_pl_next = 1'b1;
                        phase_next  = PH_SWARM;
                    end
                    PH_SWARM:  phase_next = PH_SMEAS;
                    PH_SMEAS:
                    begin
                        chosen_pl_next = !(ctime_reg < meas_reg);
                        run_pl_next    = !(ctime_reg < meas_reg);
                        run_thr_next   = chosen_thr_reg;
                        phase_next     = PH_DONE;
                    end
                    default:
                    begin
                        run_thr_next = chosen_thr_reg;
                        run_pl_next  = chosen_pl_reg;
                        phase_next   = PH_DONE;
                    end
                endcase
            end

            // Saturation test between the full and three-quarter samples.
            S_SAT_A:
            begin
                ram_raddr = sample_index(lim);
                seq_next  = S_SAT_B;
            end
            S_SAT_B:
            begin
                ram_raddr = sample_index(tq);
                y2_next   = ram_rdata;
                seq_next  = S_SAT_C;
            end
            S_SAT_C:
            begin
                den_next  = y2_reg < red_val ? y2_reg : red_val;
                diff_next = y2_reg > red_val ? y2_reg - red_val : red_val - y2_reg;
                seq_next  = S_SAT_D;
            end
            S_SAT_D:
            begin
                if (den_reg != '0 && sat_lhs <= sat_prod)
                begin
                    if (half == tq || tq == lim || half == lim)
                    begin
                        seq_next = S_BM_INIT;
                    end
                    else
                    begin
                        seq_next = S_NW_A;
                    end
                end
                else
                begin
                    low_next   = CNT_W'(1);
                    high_next  = lim;
                    phase_next = PH_GOLDEN;
                    seq_next   = S_GOLD;
                end
            end

            // Fetch the three interpolation points.
            S_NW_A:
            begin
                ram_raddr = sample_index(half);
                seq_next  = S_NW_B;
            end
            S_NW_B:
            begin
                ram_raddr = sample_index(tq);
                y0_next   = ram_rdata;
                seq_next  = S_NW_C;
            end
            S_NW_C:
            begin
                ram_raddr = sample_index(lim);
                y1_next   = ram_rdata;
                seq_next  = S_NW_D;
            end

            // Divided differences on the shared divider.
            S_NW_D:
            begin
                y2_next      = ram_rdata;
                div_start    = 1'b1;
                div_dividend = {{(DIV_BITS-TIME_BITS-17){dy01[TIME_BITS]}}, dy01, 16'd0};
                div_divisor  = tq - half;
                seq_next     = S_NW_F;
            end
            S_NW_F:
            begin
                if (div_done)
                begin
                    f_next       = div_quot;
                    div_start    = 1'b1;
                    div_dividend = {{(DIV_BITS-TIME_BITS-17){dy12[TIME_BITS]}}, dy12, 16'd0};
                    div_divisor  = lim - tq;
                    seq_next     = S_NW_G;
                end
            end
            S_NW_G:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = div_quot - f_reg;
                    div_divisor  = lim - half;
                    seq_next     = S_NW_S;
                end
            end
            S_NW_S:
            begin
                if (div_done)
                begin
                    s_next   = div_quot;
                    seq_next = S_NW_M;
                end
            end
            S_NW_M:
            begin
                m_next   = PRED_W'(m_prod);
                seq_next = S_NW_INIT;
            end

            // First forward difference at the half point.
            S_NW_INIT:
            begin
                d0_next   = PRED_W'(f_reg) + m_reg;
                d_next    = PRED_W'(f_reg) + m_reg;
                p_next    = y0q;
                t_next    = half;
                have_next = 1'b0;
                seq_next  = S_NW_SCAN1;
            end

            // Walk the prediction over half..limit for its least positive value.
            S_NW_SCAN1:
            begin
                if (p_pos && (!have_reg || p_reg < best_reg))
                begin
                    best_next = p_reg;
                    have_next = 1'b1;
                end
                if (t_reg == lim)
                begin
                    seq_next = (have_reg || p_pos) ? S_NW_MULI : S_BM_INIT;
                end
                else
                begin
                    p_next = p_reg + d_reg;
                    d_next = d_reg + s2;
                    t_next = t_reg + 1'b1;
                end
            end

            // Serial multiply of the best prediction by the tolerance.
            S_NW_MULI:
            begin
                mcand_next  = PROD_W'($unsigned(best_reg));
                mplier_next = tol_eff;
                acc_next    = '0;
                mcount_next = ($clog2(TOL_W))'(TOL_W - 1);
                seq_next    = S_NW_MUL;
            end
            S_NW_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (mcount_reg == '0)
                begin
                    seq_next = S_NW_BND;
                end
                else
                begin
                    mcount_next = mcount_reg - 1'b1;
                end
            end
            S_NW_BND:
            begin
                if (acc_reg[PROD_W-1:PRED_W-1] == '0 && bound_sum[PRED_W:PRED_W-1] == '0)
                begin
                    bound_next = $signed(bound_sum[PRED_W-1:0]);
                end
                else
                begin
                    bound_next = {1'b0, {(PRED_W-1){1'b1}}};
                end
                p_next   = y0q;
                d_next   = d0_reg;
                t_next   = half;
                seq_next = S_NW_SCAN2;
            end

            // Least count whose prediction lies within the bound.
            S_NW_SCAN2:
            begin
                if (p_pos && p_reg <= bound_reg)
                begin
                    fin_next = t_reg;
                    seq_next = S_FIN;
                end
                else if (t_reg == lim)
                begin
                    seq_next = S_BM_INIT;
                end
                else
                begin
                    p_next = p_reg + d_reg;
                    d_next = d_reg + s2;
                    t_next = t_reg + 1'b1;
                end
            end

            // Walk the store for the best measured count.
            S_BM_INIT:
            begin
                t_next     = CNT_W'(1);
                found_next = 1'b0;
                bt_next    = lim;
                seq_next   = S_BM_RD;
            end
            S_BM_RD:
            begin
                ram_raddr = sample_index(t_reg);
                seq_next  = S_BM_CMP;
            end
            S_BM_CMP:
            begin
                if (bm_take)
                begin
                    found_next = 1'b1;
                    bv_next    = ram_rdata;
                    bt_next    = t_reg;
                end
                if (t_reg >= lim)
                begin
                    fin_next = bm_take ? t_reg : bt_reg;
                    seq_next = S_FIN;
                end
                else
                begin
                    t_next   = t_reg + 1'b1;
                    seq_next = S_BM_RD;
                end
            end

            // Fix the thread count and move on to placement if it is enabled, else to done.
            S_FIN:
            begin
                chosen_thr_next = fin_clamped;
                run_thr_next    = fin_clamped;
                run_pl_next     = 1'b0;
                phase_next      = place_reg ? PH_CWARM : PH_DONE;
                seq_next        = S_OUT;
            end

            // One golden-section step over the interval.
            S_GOLD:
            begin
                if (!g_cont)
                begin
                    seq_next = S_GOLD_END;
                end
                else if (g_span == CNT_W'(2))
                begin
                    if (!valid_reg[sample_index(g_mid)])
                    begin
                        run_thr_next = g_mid;
                        seq_next     = S_OUT;
                    end
                    else
                    begin
                        seq_next = S_GOLD_END;
                    end
                end
                else if (g_span < CNT_W'(3) || g_left >= g_right)
                begin
                    seq_next = S_GOLD_END;
                end
                else if (!valid_reg[sample_index(g_left)])
                begin
                    run_thr_next = g_left;
                    seq_next     = S_OUT;
                end
                else if (!valid_reg[sample_index(g_right)])
                begin
                    run_thr_next = g_right;
                    seq_next     = S_OUT;
                end
                else
                begin
                    left_next  = g_left;
                    right_next = g_right;
                    seq_next   = S_GOLD_RL;
                end
            end
            S_GOLD_RL:
            begin
                ram_raddr = sample_index(left_reg);
                seq_next  = S_GOLD_RR;
            end
            S_GOLD_RR:
            begin
                ram_raddr = sample_index(right_reg);
                lt_next   = ram_rdata;
                seq_next  = S_GOLD_CMP;
            end
            S_GOLD_CMP:
            begin
                if (lt_reg <= ram_rdata)
                begin
                    high_next = right_reg;
                end
                else
                begin
                    low_next = left_reg;
                end
                seq_next = S_GOLD;
            end
            S_GOLD_END:
            begin
                if (!valid_reg[sample_index(low_reg)])
                begin
                    run_thr_next = low_reg;
                    seq_next     = S_OUT;
                end
                else if (!valid_reg[sample_index(high_reg)])
                begin
                    run_thr_next = high_reg;
                    seq_next     = S_OUT;
                end
                else
                begin
                    seq_next = S_BM_INIT;
                end
            end

            // Present the result word until it is taken.
            S_OUT:
            begin
                outcome.valid = 1'b1;
                if (outcome.ready)
                begin
                    seq_next = S_IDLE;
                end
            end

            default: seq_next = S_IDLE;
        endcase
    end

    // Control and search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= CNT_W'(MAX_THREADS);
            tol_reg        <= TOL_W'(3277);
            stop_reg       <= '0;
            place_reg      <= 1'b1;
            seq_reg        <= S_IDLE;
            phase_reg      <= PH_WARM1;
            run_thr_reg    <= CNT_W'(MAX_THREADS);
            chosen_thr_reg <= CNT_W'(MAX_THREADS);
            run_pl_reg     <= 1'b0;
            chosen_pl_reg  <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            ctime_reg      <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            limit_reg      <= limit_next;
            tol_reg        <= tol_next;
            stop_reg       <= stop_next;
            place_reg      <= place_next;
            seq_reg        <= seq_next;
            phase_reg      <= phase_next;
            run_thr_reg    <= run_thr_next;
            chosen_thr_reg <= chosen_thr_next;
            run_pl_reg     <= run_pl_next;
            chosen_pl_reg  <= chosen_pl_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            ctime_reg      <= ctime_next;
            valid_reg      <= valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        y2_reg     <= y2_next;
        den_reg    <= den_next;
        diff_reg   <= diff_next;
        f_reg      <= f_next;
        s_reg      <= s_next;
        m_reg      <= m_next;
        d0_reg     <= d0_next;
        d_reg      <= d_next;
        p_reg      <= p_next;
        best_reg   <= best_next;
        bound_reg  <= bound_next;
        have_reg   <= have_next;
        t_reg      <= t_next;
        found_reg  <= found_next;
        bv_reg     <= bv_next;
        bt_reg     <= bt_next;
        fin_reg    <= fin_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        mcount_reg <= mcount_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        lt_reg     <= lt_next;
    end

    // Sample store.
    tca_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_samples (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (sample_index(run_thr_reg)),
        .wr_data (meas_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Slope divider.
    tca_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Result word.
    assign outcome.next_threads   = run_thr_reg;
    assign outcome.next_placement = run_pl_reg;
    assign outcome.phase_code     = phase_reg;
    assign outcome.tuning_done    = phase_reg == PH_DONE;

    // A pending result blocks new words.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        outcome.valid |-> !measure.ready)
        else $error("input taken while a result is pending");

    // Reported thread counts stay within the store.
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        outcome.valid |-> (run_thr_reg != '0 && run_thr_reg <= CNT_W'(MAX_THREADS)))
        else $error("thread count out of range");

    // Count zero is never recorded.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0])
        else $error("sample slot zero marked valid");

    // The divider only starts on the Newton path.
    a_div_use: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (seq_reg == S_NW_D || seq_reg == S_NW_F || seq_reg == S_NW_G))
        else $error("divider started outside interpolation");

endmodule
